// ===== sv/adp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the coefficient ROM for the diffusion pass.
// Used by adp_term and anisotropic_diffusion_pass; depends on nothing.
package adp_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WCLAMP_W   = $clog2(MAX_WIDTH + 1);
  localparam int HCLAMP_W   = $clog2(MAX_HEIGHT + 1);

  localparam int WIDTH_CFG_W  = 12;
  localparam int HEIGHT_CFG_W = 13;
  localparam int KINV_W       = 25;
  localparam int LAMBDA_W     = 17;
  localparam int PIX_W        = 8;
  localparam int DIFF_W       = PIX_W + 1;
  localparam int COEF_W       = 17;
  localparam int TERM_W       = COEF_W + 1 + DIFF_W;
  localparam int SUM_W        = TERM_W + 2;
  localparam int PROD_W       = LAMBDA_W + 1 + SUM_W;
  localparam int T_W          = PROD_W + 2;
  localparam int SQ_W         = 2 * PIX_W;
  localparam int M1_W         = SQ_W + KINV_W;
  localparam int LOG2E_W      = 17;
  localparam int E_W          = M1_W + LOG2E_W;
  localparam int EXP_INT_LO   = 40;
  localparam int EXP_FRAC_LO  = 32;
  localparam int SHIFT_LIMIT  = 17;

  localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [KINV_W-1:0]       KINV_RST   = 25'd74565;
  localparam logic [LAMBDA_W-1:0]     LAMBDA_RST = 17'd16384;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_INV_K_SQ,
    REG_LAMBDA_GAIN
  } reg_idx_t;

  // Per-request bookkeeping that travels down the pipeline with the data.
  typedef struct packed {
    logic             has1;
    logic             border1;
    logic             last1;
    logic             has2;
    logic             eof2;
    logic             sel;
    logic [PIX_W-1:0] pin;
    logic [PIX_W-1:0] pixc;
  } meta_t;

  localparam logic [31:0] POW_K [8] = '{
    32'd4283353945, 32'd4271771996, 32'd4248701965, 32'd4202935003,
    32'd4112874773, 32'd3938502376, 32'd3611622603, 32'd3037000500
  };

  typedef logic [COEF_W-1:0] frac_rom_t [256];

  // 2^-(f/256) in Q1.16, built by chained Q0.32 products over the set bits of f.
  function automatic frac_rom_t build_frac_rom();
    frac_rom_t   rom;
    logic [63:0] v;
    for (int f = 0; f < 256; f++) begin
      v = 64'h1_0000_0000;
      for (int b = 0; b < 8; b++) begin
        if (((f >> b) & 1) != 0) begin
          v = (v * {32'd0, POW_K[b]} + 64'h8000_0000) >> 32;
        end
      end
      rom[f] = COEF_W'((v + 64'd32768) >> 16);
    end
    return rom;
  endfunction

  localparam frac_rom_t FRAC_ROM = build_frac_rom();

endpackage

// ===== sv/anisotropic_diffusion_pass.sv =====
`timescale 1ns / 1ps
// One Perona-Malik diffusion pass over a raster pixel stream, two line stores.
// Throughput: one request per cycle while the output is not stalled; a last-row request
// holds the input while its second, pending result waits in the output slot.
// The output register drains while the next request enters; a stall freezes every stage.
// Synchronous active-low reset clears counters, valid bits and config registers to defaults;
// the line stores are not cleared. Depends on adp_pkg, adp_ram and adp_term.
module anisotropic_diffusion_pass (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [adp_pkg::PIX_W-1:0]         in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [adp_pkg::PIX_W-1:0]         out_pixel_out,
  output logic                              out_is_border,
  output logic                              out_end_of_frame,
  output logic                              out_last_of_run,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [adp_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [adp_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [adp_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam int NSTG = 9;

  // Configuration registers.
  logic [adp_pkg::WIDTH_CFG_W-1:0]  width_r;
  logic [adp_pkg::HEIGHT_CFG_W-1:0] height_r;
  logic [adp_pkg::KINV_W-1:0]       kinv_r;
  logic [adp_pkg::LAMBDA_W-1:0]     lambda_r;
  adp_pkg::reg_idx_t                cfg_idx;
  logic                             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = adp_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= adp_pkg::WIDTH_RST;
      height_r <= adp_pkg::HEIGHT_RST;
      kinv_r   <= adp_pkg::KINV_RST;
      lambda_r <= adp_pkg::LAMBDA_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        adp_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[adp_pkg::WIDTH_CFG_W-1:0];
        adp_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[adp_pkg::HEIGHT_CFG_W-1:0];
        adp_pkg::REG_INV_K_SQ:     kinv_r   <= cfg_pwdata[adp_pkg::KINV_W-1:0];
        adp_pkg::REG_LAMBDA_GAIN:  lambda_r <= cfg_pwdata[adp_pkg::LAMBDA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      adp_pkg::REG_IMAGE_WIDTH:  cfg_prdata = adp_pkg::CFG_DW'(width_r);
      adp_pkg::REG_IMAGE_HEIGHT: cfg_prdata = adp_pkg::CFG_DW'(height_r);
      adp_pkg::REG_INV_K_SQ:     cfg_prdata = adp_pkg::CFG_DW'(kinv_r);
      adp_pkg::REG_LAMBDA_GAIN:  cfg_prdata = adp_pkg::CFG_DW'(lambda_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Clamped frame size.
  logic [adp_pkg::WCLAMP_W-1:0] wc;
  logic [adp_pkg::HCLAMP_W-1:0] hc;

  always_comb begin
    if (width_r < adp_pkg::WIDTH_CFG_W'(3)) begin
      wc = adp_pkg::WCLAMP_W'(3);
    end else if (width_r > adp_pkg::WIDTH_CFG_W'(adp_pkg::MAX_WIDTH)) begin
      wc = adp_pkg::WCLAMP_W'(adp_pkg::MAX_WIDTH);
    end else begin
      wc = adp_pkg::WCLAMP_W'(width_r);
    end
    if (height_r < adp_pkg::HEIGHT_CFG_W'(3)) begin
      hc = adp_pkg::HCLAMP_W'(3);
    end else if (height_r > adp_pkg::HEIGHT_CFG_W'(adp_pkg::MAX_HEIGHT)) begin
      hc = adp_pkg::HCLAMP_W'(adp_pkg::MAX_HEIGHT);
    end else begin
      hc = adp_pkg::HCLAMP_W'(height_r);
    end
  end

  // Pipeline advance, set by the output slot.
  logic adv, in_acc, out_acc;

  assign in_stall = ~adv;
  assign in_acc   = in_valid & adv;

  // Raster position counters.
  logic [adp_pkg::COL_W-1:0] col_r, col_nxt;
  logic [adp_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                      sel_r, sel_nxt;
  logic [adp_pkg::COL_W-1:0] c0;
  logic [adp_pkg::HCLAMP_W-1:0] r0, r1;
  logic [adp_pkg::WCLAMP_W-1:0] c1;
  logic                      sel0;

  always_comb begin
    c0   = col_r;
    r0   = adp_pkg::HCLAMP_W'(row_r);
    sel0 = sel_r;
    // A size change can leave the counters beyond the frame; close the row first.
    if (adp_pkg::WCLAMP_W'(col_r) >= wc) begin
      c0   = '0;
      r0   = adp_pkg::HCLAMP_W'(row_r) + 1'b1;
      sel0 = ~sel_r;
    end
    if (r0 >= hc) begin
      r0 = '0;
      c0 = '0;
    end
    c1      = adp_pkg::WCLAMP_W'(c0) + 1'b1;
    r1      = r0 + 1'b1;
    col_nxt = adp_pkg::COL_W'(c1);
    row_nxt = adp_pkg::ROW_W'(r0);
    sel_nxt = sel0;
    if (c1 >= wc) begin
      col_nxt = '0;
      sel_nxt = ~sel0;
      row_nxt = (r1 >= hc) ? '0 : adp_pkg::ROW_W'(r1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      sel_r <= 1'b0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      sel_r <= sel_nxt;
    end
  end

  // Line stores: sel0 picks the store that is overwritten; the other holds the row above.
  logic [adp_pkg::PIX_W-1:0] a_rd_c, a_rd_n, b_rd_c, b_rd_n;
  logic [adp_pkg::COL_W-1:0] c0_next;

  assign c0_next = c0 + 1'b1;

  adp_ram #(.WIDTH(adp_pkg::PIX_W), .DEPTH(adp_pkg::MAX_WIDTH)) u_store_a (
    .clk     (clk),
    .we      (in_acc & sel0),
    .waddr   (c0),
    .wdata   (in_pixel_in),
    .re      (in_acc),
    .raddr_a (c0),
    .raddr_b (c0_next),
    .rdata_a (a_rd_c),
    .rdata_b (a_rd_n)
  );

  adp_ram #(.WIDTH(adp_pkg::PIX_W), .DEPTH(adp_pkg::MAX_WIDTH)) u_store_b (
    .clk     (clk),
    .we      (in_acc & ~sel0),
    .waddr   (c0),
    .wdata   (in_pixel_in),
    .re      (in_acc),
    .raddr_a (c0),
    .raddr_b (c0_next),
    .rdata_a (b_rd_c),
    .rdata_b (b_rd_n)
  );

  // Stage valid bits and bookkeeping.
  logic          vld_r  [NSTG];
  adp_pkg::meta_t meta_r [NSTG];
  adp_pkg::meta_t meta_in;

  always_comb begin
    meta_in         = '0;
    meta_in.has1    = (r0 != '0);
    meta_in.border1 = (r0 == adp_pkg::HCLAMP_W'(1)) || (c0 == '0)
                      || (adp_pkg::WCLAMP_W'(c0) == wc - 1'b1);
    meta_in.last1   = (r0 != hc - 1'b1);
    meta_in.has2    = (r0 == hc - 1'b1);
    meta_in.eof2    = (adp_pkg::WCLAMP_W'(c0) == wc - 1'b1);
    meta_in.sel     = sel0;
    meta_in.pin     = in_pixel_in;
  end

  // Window assembly from the store outputs.
  logic [adp_pkg::PIX_W-1:0] pix_s1, up_s1, rt_s1, left_r;
  adp_pkg::meta_t            meta_s1;

  assign pix_s1 = meta_r[0].sel ? b_rd_c : a_rd_c;
  assign rt_s1  = meta_r[0].sel ? b_rd_n : a_rd_n;
  assign up_s1  = meta_r[0].sel ? a_rd_c : b_rd_c;

  always_comb begin
    meta_s1      = meta_r[0];
    meta_s1.pixc = pix_s1;
  end

  logic signed [adp_pkg::DIFF_W-1:0] d_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= meta_in;
      meta_r[1] <= meta_s1;
      for (int i = 2; i < NSTG; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
      if (vld_r[0]) begin
        left_r <= pix_s1;
      end
      d_r[0] <= $signed({1'b0, left_r}) - $signed({1'b0, pix_s1});
      d_r[1] <= $signed({1'b0, rt_s1})  - $signed({1'b0, pix_s1});
      d_r[2] <= $signed({1'b0, up_s1})  - $signed({1'b0, pix_s1});
      d_r[3] <= $signed({1'b0, meta_r[0].pin}) - $signed({1'b0, pix_s1});
    end
  end

  // Four conduction lanes.
  logic signed [adp_pkg::TERM_W-1:0] term_w [4];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    adp_term u_term (
      .clk      (clk),
      .adv      (adv),
      .diff     (d_r[g]),
      .inv_k_sq (kinv_r),
      .term     (term_w[g])
    );
  end

  logic signed [adp_pkg::SUM_W-1:0]  sum_r;
  logic signed [adp_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= adp_pkg::SUM_W'(term_w[0]) + adp_pkg::SUM_W'(term_w[1])
             + adp_pkg::SUM_W'(term_w[2]) + adp_pkg::SUM_W'(term_w[3]);
      prod_r <= $signed({1'b0, lambda_r}) * sum_r;
    end
  end

  // Truncate toward zero and saturate to a pixel.
  logic signed [adp_pkg::T_W-1:0]     t_full;
  logic [adp_pkg::T_W-33:0]           t_int;
  logic [adp_pkg::PIX_W-1:0]          filt;
  adp_pkg::meta_t                     meta_o;

  assign meta_o = meta_r[NSTG-1];
  assign t_full = $signed({1'b0, meta_o.pixc, 32'd0}) + adp_pkg::T_W'(prod_r);
  assign t_int  = t_full[adp_pkg::T_W-1:32];

  always_comb begin
    if (t_full[adp_pkg::T_W-1]) begin
      filt = '0;
    end else if (t_int > (adp_pkg::T_W-32)'(255)) begin
      filt = '1;
    end else begin
      filt = t_int[adp_pkg::PIX_W-1:0];
    end
  end

  // Output slot with one pending last-row result.
  logic                      ov_r, ov_nxt;
  logic                      pend_r, pend_nxt;
  logic [adp_pkg::PIX_W-1:0] opix_r, opix_nxt, ppix_r, ppix_nxt;
  logic                      obord_r, obord_nxt, oeof_r, oeof_nxt, olast_r, olast_nxt;
  logic                      peof_r, peof_nxt;

  assign out_acc = ov_r & ~out_stall;
  assign adv     = ~ov_r | (out_acc & ~pend_r);

  always_comb begin
    ov_nxt    = ov_r;
    pend_nxt  = pend_r;
    opix_nxt  = opix_r;
    obord_nxt = obord_r;
    oeof_nxt  = oeof_r;
    olast_nxt = olast_r;
    ppix_nxt  = ppix_r;
    peof_nxt  = peof_r;
    if (adv) begin
      ppix_nxt = meta_o.pin;
      peof_nxt = meta_o.eof2;
      if (vld_r[NSTG-1] && meta_o.has1) begin
        ov_nxt    = 1'b1;
        opix_nxt  = meta_o.border1 ? meta_o.pixc : filt;
        obord_nxt = meta_o.border1;
        oeof_nxt  = 1'b0;
        olast_nxt = meta_o.last1;
        pend_nxt  = meta_o.has2;
      end else if (vld_r[NSTG-1] && meta_o.has2) begin
        ov_nxt    = 1'b1;
        opix_nxt  = meta_o.pin;
        obord_nxt = 1'b1;
        oeof_nxt  = meta_o.eof2;
        olast_nxt = 1'b1;
        pend_nxt  = 1'b0;
      end else begin
        ov_nxt   = 1'b0;
        pend_nxt = 1'b0;
      end
    end else if (out_acc) begin
      opix_nxt  = ppix_r;
      obord_nxt = 1'b1;
      oeof_nxt  = peof_r;
      olast_nxt = 1'b1;
      pend_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      ov_r   <= ov_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opix_r  <= opix_nxt;
    obord_r <= obord_nxt;
    oeof_r  <= oeof_nxt;
    olast_r <= olast_nxt;
    ppix_r  <= ppix_nxt;
    peof_r  <= peof_nxt;
  end

  assign out_valid        = ov_r;
  assign out_pixel_out    = opix_r;
  assign out_is_border    = obord_r;
  assign out_end_of_frame = oeof_r;
  assign out_last_of_run  = olast_r;

  // A pending second result always sits behind a shown first one.
  a_pend_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ov_r) else $error("pending result without a shown result");

  // A held result freezes the whole pipeline.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |-> in_stall) else $error("input taken while output held");

  // The frame end is a border pixel and ends its run.
  a_eof_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oeof_r) |-> (olast_r && obord_r)) else $error("bad end-of-frame flags");

endmodule

// ===== sv/adp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, dual-read RAM with registered, read-first outputs.
// Standalone; no package dependency.
module adp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== sv/adp_term.sv =====
`timescale 1ns / 1ps
// One conduction term c*d, c = 2^-(d^2 * inv_k_sq * log2 e), five register stages.
// Depends on adp_pkg for widths and the fraction ROM.
module adp_term (
  input  logic                                clk,
  input  logic                                adv,
  input  logic signed [adp_pkg::DIFF_W-1:0]   diff,
  input  logic [adp_pkg::KINV_W-1:0]          inv_k_sq,
  output logic signed [adp_pkg::TERM_W-1:0]   term
);

  logic signed [adp_pkg::DIFF_W-1:0] d_a_r, d_b_r, d_c_r, d_d_r;
  logic [adp_pkg::SQ_W-1:0]          sq_r;
  logic [adp_pkg::M1_W-1:0]          m1_r;
  logic                              big_r;
  logic [4:0]                        shift_r;
  logic [7:0]                        frac_r;
  logic [adp_pkg::COEF_W-1:0]        coef_r;
  logic signed [adp_pkg::TERM_W-1:0] term_r;

  logic signed [2*adp_pkg::DIFF_W-1:0] sq_full;
  logic [adp_pkg::E_W-1:0]             e;

  assign sq_full = diff * diff;
  assign e = adp_pkg::E_W'(m1_r) * adp_pkg::E_W'(adp_pkg::LOG2E_Q16);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_a_r <= diff;
      sq_r  <= adp_pkg::SQ_W'(sq_full);
      d_b_r <= d_a_r;
      m1_r  <= adp_pkg::M1_W'(sq_r) * adp_pkg::M1_W'(inv_k_sq);
      d_c_r <= d_b_r;
      // The integer part of the exponent turns into a right shift.
      big_r <= (|e[adp_pkg::E_W-1:adp_pkg::EXP_INT_LO+5])
               || (e[adp_pkg::EXP_INT_LO+4:adp_pkg::EXP_INT_LO] >= 5'(adp_pkg::SHIFT_LIMIT));
      shift_r <= e[adp_pkg::EXP_INT_LO+4:adp_pkg::EXP_INT_LO];
      frac_r  <= e[adp_pkg::EXP_INT_LO-1:adp_pkg::EXP_FRAC_LO];
      d_d_r   <= d_c_r;
      coef_r  <= big_r ? '0 : (adp_pkg::FRAC_ROM[frac_r] >> shift_r);
      term_r  <= $signed({1'b0, coef_r}) * d_d_r;
    end
  end

  assign term = term_r;

endmodule

// ===== tb/tb_anisotropic_diffusion_pass.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for anisotropic_diffusion_pass: streams frames and compares each
// result with a behavioral diffusion predictor. Depends on adp_pkg and the block's RTL.
module tb_anisotropic_diffusion_pass;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0] pix;
    logic       border;
    logic       eof;
    logic       last;
  } px_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_pixel_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pixel_out;
  logic        out_is_border;
  logic        out_end_of_frame;
  logic        out_last_of_run;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [adp_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [adp_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [adp_pkg::CFG_DW-1:0] cfg_prdata;
  logic        cfg_pready;

  anisotropic_diffusion_pass dut (.*);

  always #2 clk = ~clk;

  // Predictor state.
  logic [16:0] coef_rom [256];
  logic [7:0]  line_mem [2][adp_pkg::MAX_WIDTH];
  int          col_cnt, row_cnt;
  logic        new_sel;
  logic [11:0] m_width;
  logic [12:0] m_height;
  logic [24:0] m_kinv;
  logic [16:0] m_lambda;

  px_result_t  expected_px[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  int          hold_left = 0;

  localparam logic [31:0] POW_TAB [8] = '{
    32'd4283353945, 32'd4271771996, 32'd4248701965, 32'd4202935003,
    32'd4112874773, 32'd3938502376, 32'd3611622603, 32'd3037000500
  };

  function automatic longint coef_term(int d);
    longint unsigned d2, e, s;
    logic [7:0] f;
    longint c;
    d2 = longint'(d) * longint'(d);
    e = d2 * longint'(m_kinv) * 64'd94548;
    s = e >> 40;
    f = e[39:32];
    if (s >= 17) return 0;
    c = longint'(coef_rom[f] >> s);
    return c * d;
  endfunction

  function automatic logic [7:0] diffuse_px(int p, int lf, int rt, int up, int dn);
    longint sum, t;
    sum = coef_term(lf - p) + coef_term(rt - p) + coef_term(up - p) + coef_term(dn - p);
    t = (longint'(p) <<< 32) + longint'(m_lambda) * sum;
    if (t < 0) return 8'd0;
    t = t >>> 32;
    return (t > 255) ? 8'd255 : t[7:0];
  endfunction

  task automatic predict_pixel(input logic [7:0] p);
    int w, h, c, r;
    px_result_t res;
    logic [7:0] ctr;
    w = (m_width < 3) ? 3 : (m_width > adp_pkg::MAX_WIDTH) ? adp_pkg::MAX_WIDTH : m_width;
    h = (m_height < 3) ? 3 : (m_height > adp_pkg::MAX_HEIGHT) ? adp_pkg::MAX_HEIGHT
                                                                : m_height;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      new_sel = ~new_sel;
    end
    if (row_cnt >= h) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    c = col_cnt;
    r = row_cnt;
    if (r >= 1) begin
      ctr = line_mem[new_sel][c];
      res.last = (r != h - 1);
      res.eof = 1'b0;
      if (r == 1 || c == 0 || c == w - 1) begin
        res.pix = ctr;
        res.border = 1'b1;
      end else begin
        res.pix = diffuse_px(ctr, line_mem[new_sel][c-1], line_mem[new_sel][c+1],
                             line_mem[~new_sel][c], p);
        res.border = 1'b0;
      end
      expected_px.push_back(res);
    end
    if (r == h - 1) begin
      res.pix = p;
      res.border = 1'b1;
      res.eof = (c == w - 1);
      res.last = 1'b1;
      expected_px.push_back(res);
    end
    line_mem[~new_sel][c] = p;
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      new_sel = ~new_sel;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  function automatic int gap_len();
    int k;
    if (quiet) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pixel(input logic [7:0] p);
    int g;
    in_valid <= 1'b1;
    in_pixel_in <= p;
    do @(posedge clk); while (in_stall);
    predict_pixel(p);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input adp_pkg::reg_idx_t idx, input logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= adp_pkg::CFG_AW'(idx) << 2;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      adp_pkg::REG_IMAGE_WIDTH: m_width = v[11:0];
      adp_pkg::REG_IMAGE_HEIGHT: m_height = v[12:0];
      adp_pkg::REG_INV_K_SQ: m_kinv = v[24:0];
      default: m_lambda = v[16:0];
    endcase
  endtask

  task automatic set_frame(input int w, input int h, input int kinv, input int lam);
    wait_drained();
    cfg_write(adp_pkg::REG_IMAGE_WIDTH, w);
    cfg_write(adp_pkg::REG_IMAGE_HEIGHT, h);
    cfg_write(adp_pkg::REG_INV_K_SQ, kinv);
    cfg_write(adp_pkg::REG_LAMBDA_GAIN, lam);
    @(posedge clk);
  endtask

  function automatic int eff_w();
    return (m_width < 3) ? 3 : (m_width > adp_pkg::MAX_WIDTH) ? adp_pkg::MAX_WIDTH : m_width;
  endfunction

  function automatic int eff_h();
    return (m_height < 3) ? 3 : (m_height > adp_pkg::MAX_HEIGHT) ? adp_pkg::MAX_HEIGHT
                                                                   : m_height;
  endfunction

  // Smooth frames keep neighbor differences small so the coefficients are less often zero.
  task automatic send_frame(input bit smooth);
    int n, base, v;
    base = $urandom_range(0, 255);
    n = eff_w() * eff_h();
    for (int i = 0; i < n; i++) begin
      if (smooth) begin
        v = base + $urandom_range(0, 30) - 15;
        v = (v < 0) ? 0 : (v > 255) ? 255 : v;
      end else begin
        v = $urandom_range(0, 255);
      end
      send_pixel(v[7:0]);
    end
  endtask

  task automatic test_directed_extremes();
    set_frame(3, 3, 74565, 16384);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'hFF : 8'h00);
    // No edge stopping and a gain of 65536 drive both saturation limits.
    set_frame(5, 3, 0, 65536);
    for (int i = 0; i < 15; i++) send_pixel((i == 6) ? 8'h00 : (i == 8) ? 8'hFF :
                                            (i % 3 == 0) ? 8'hAA : 8'h55);
  endtask

  task automatic test_size_clamp();
    set_frame(0, 1, 16777216, 1);
    send_frame(1'b0);
    set_frame(1, 40, 5000, 30000);
    send_frame(1'b1);
    set_frame(40, 2, 200000, 65535);
    send_frame(1'b1);
  endtask

  task automatic test_random_frames();
    int items;
    items = 0;
    while (items < 1600) begin
      quiet = ($urandom_range(0, 5) == 0);
      set_frame($urandom_range(3, 40), $urandom_range(3, 12),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777216)
                                            : $urandom_range(1000, 300000),
                $urandom_range(0, 65536));
      items += eff_w() * eff_h();
      send_frame($urandom_range(0, 3) != 0);
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    set_frame(8, 4, 74565, 16384);
    quiet = 1'b1;
    hold_left = 300;
    send_frame(1'b1);
    quiet = 1'b0;
  endtask

  // Receiver: random stall runs, plus a long hold when a test requests one.
  initial begin
    int run_left;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        out_stall <= ($urandom_range(0, 9) < 3);
        run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk) begin
    px_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected result pixel=%0d", $time, out_pixel_out);
        errors++;
      end else begin
        exp_r = expected_px.pop_front();
        if (out_pixel_out !== exp_r.pix) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time, exp_r.pix, out_pixel_out);
          errors++;
        end
        if (out_is_border !== exp_r.border) begin
          $display("%0t: is_border expected %0b actual %0b", $time, exp_r.border,
                   out_is_border);
          errors++;
        end
        if (out_end_of_frame !== exp_r.eof) begin
          $display("%0t: end_of_frame expected %0b actual %0b", $time, exp_r.eof,
                   out_end_of_frame);
          errors++;
        end
        if (out_last_of_run !== exp_r.last) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, exp_r.last,
                   out_last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("anisotropic_diffusion_pass: mismatch");
      $finish;
    end
  end

  initial begin
    logic [63:0] v;
    for (int f = 0; f < 256; f++) begin
      v = 64'h1_0000_0000;
      for (int b = 0; b < 8; b++) begin
        if (f[b]) v = (v * {32'd0, POW_TAB[b]} + 64'h8000_0000) >> 32;
      end
      coef_rom[f] = 17'((v + 64'd32768) >> 16);
    end
    col_cnt = 0;
    row_cnt = 0;
    new_sel = 1'b0;
    m_width = 12'd640;
    m_height = 13'd480;
    m_kinv = 25'd74565;
    m_lambda = 17'd16384;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_size_clamp();
    test_backpressure();
    test_random_frames();
    wait_drained();
    if (errors == 0) begin
      $display("anisotropic_diffusion_pass: match");
    end else begin
      $display("anisotropic_diffusion_pass: mismatch");
    end
    $finish;
  end

endmodule
